// ===== rtl/rtdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdseq_pkg
// Shared types and constants for the inverter ready-to-drive sequencer.
// ----------------------------------------------------------------------------
package rtdseq_pkg;

    // Engines whose status bits take part in the "any engine" reductions
    localparam int NUM_ENGINES = 4;
    localparam int ENGINE_BITS = 4;

    // Sequencer phase codes
    localparam logic [1:0] PH_OFF       = 2'd0;
    localparam logic [1:0] PH_PRECHARGE = 2'd1;
    localparam logic [1:0] PH_TS_READY  = 2'd2;
    localparam logic [1:0] PH_RUNNING   = 2'd3;

    // Configuration register indexes (word address bit 2)
    localparam logic REG_BRAKE_THRESHOLD  = 1'b0;
    localparam logic REG_SEND_INTERVAL_MS = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [6:0] BRAKE_THRESHOLD_RESET  = 7'd20;
    localparam logic [9:0] SEND_INTERVAL_MS_RESET = 10'd10;

    typedef struct packed {
        logic [ENGINE_BITS-1:0] ready_bits;
        logic [ENGINE_BITS-1:0] hv_on_bits;
        logic [ENGINE_BITS-1:0] hv_ack_bits;
        logic [ENGINE_BITS-1:0] inv_ack_bits;
        logic                   precharge_init_line;
        logic                   precharge_done_line;
        logic                   drive_request;
        logic [6:0]             brake_level;
        logic                   power_unit_ack;
        logic [31:0]            now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       send_now;
        logic       cmd_hv_on;
        logic       cmd_inverter_on;
        logic       cmd_enable;
        logic       pu_mode;
        logic       pu_request;
        logic       fault;
    } result_t;

    typedef struct packed {
        logic [6:0] brake_threshold;
        logic [9:0] send_interval_ms;
    } cfg_t;

    // True when any of the participating engine bits is set
    function automatic logic any_engine(input logic [ENGINE_BITS-1:0] bits);
        return |bits[NUM_ENGINES-1:0];
    endfunction

endpackage

// ===== rtl/rtdseq_regs.sv =====
// ----------------------------------------------------------------------------
// rtdseq_regs
// APB-style configuration registers: brake threshold and send interval.
// ----------------------------------------------------------------------------
module rtdseq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtdseq_pkg::PADDR_W-1:0] paddr,
    input  logic [rtdseq_pkg::PDATA_W-1:0] pwdata,
    output logic [rtdseq_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output rtdseq_pkg::cfg_t              cfg
);

    logic [6:0] brake_threshold_reg;
    logic [9:0] send_interval_ms_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_threshold_reg  <= rtdseq_pkg::BRAKE_THRESHOLD_RESET;
            send_interval_ms_reg <= rtdseq_pkg::SEND_INTERVAL_MS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                rtdseq_pkg::REG_BRAKE_THRESHOLD:  brake_threshold_reg  <= pwdata[6:0];
                rtdseq_pkg::REG_SEND_INTERVAL_MS: send_interval_ms_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_sel)
            rtdseq_pkg::REG_BRAKE_THRESHOLD:
                prdata = {{(rtdseq_pkg::PDATA_W-7){1'b0}}, brake_threshold_reg};
            rtdseq_pkg::REG_SEND_INTERVAL_MS:
                prdata = {{(rtdseq_pkg::PDATA_W-10){1'b0}}, send_interval_ms_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.brake_threshold  = brake_threshold_reg;
    assign cfg.send_interval_ms = send_interval_ms_reg;

endmodule

// ===== rtl/rtdseq_core.sv =====
// ----------------------------------------------------------------------------
// rtdseq_core
// Input register, phase sequencer with send timer, and result register.
// ----------------------------------------------------------------------------
module rtdseq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtdseq_pkg::cfg_t     cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rtdseq_pkg::item_t    item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output rtdseq_pkg::result_t  result
);

    // Pipeline registers
    logic                s1_valid_reg;
    logic                s1_valid_next;
    rtdseq_pkg::item_t   s1_item_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    rtdseq_pkg::result_t res_reg;
    rtdseq_pkg::result_t res_next;

    // Sequencer state
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        mark_reg;
    logic        mark_next;
    logic        fault_reg;
    logic        fault_next;
    logic [31:0] last_send_reg;
    logic [31:0] last_send_next;

    logic advance;
    logic accept;

    // Decoded item
    logic        ready;
    logic        hv_on;
    logic        hv_ack;
    logic        inv_ack;
    logic        init_line;
    logic        done_line;
    logic        drive;
    logic        ended;
    logic        failed;
    logic        may_send;
    logic        fault_cur;
    logic        dc_on;
    logic        inv_on;
    logic        enable;
    logic        mode;
    logic        req;
    logic        send;
    logic [31:0] elapsed;

    // Move an item forward when the result slot is free or being drained
    assign advance    = s1_valid_reg & (~res_valid_reg | result_ready);
    assign item_ready = ~s1_valid_reg | advance;
    assign accept     = item_valid & item_ready;

    assign s1_valid_next  = accept | (s1_valid_reg & ~advance);
    assign res_valid_next = advance | (res_valid_reg & ~result_ready);

    assign ready     = rtdseq_pkg::any_engine(s1_item_reg.ready_bits);
    assign hv_on     = rtdseq_pkg::any_engine(s1_item_reg.hv_on_bits);
    assign hv_ack    = rtdseq_pkg::any_engine(s1_item_reg.hv_ack_bits);
    assign inv_ack   = rtdseq_pkg::any_engine(s1_item_reg.inv_ack_bits);
    assign init_line = s1_item_reg.precharge_init_line;
    assign done_line = s1_item_reg.precharge_done_line;
    assign drive     = s1_item_reg.drive_request;

    // Step the phase sequencer for the held item
    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        fault_cur  = (phase_reg == rtdseq_pkg::PH_OFF) ? 1'b0 : fault_reg;
        dc_on      = 1'b0;
        inv_on     = 1'b0;
        enable     = 1'b0;
        mode       = 1'b0;
        req        = 1'b0;
        may_send   = 1'b1;
        failed     = 1'b0;
        ended      = hv_ack & mark_reg & ~init_line & done_line;

        unique case (phase_reg)
            rtdseq_pkg::PH_OFF:
            begin
                mark_next = 1'b0;
                dc_on     = ready;
                if (!fault_cur && ready && hv_on && hv_ack && !init_line && !done_line
                    && !drive)
                begin
                    phase_next = rtdseq_pkg::PH_PRECHARGE;
                end
                else if (drive || fault_cur)
                begin
                    failed = 1'b1;
                end
            end
            rtdseq_pkg::PH_PRECHARGE:
            begin
                mark_next = 1'b1;
                dc_on     = 1'b1;
                if (!ready || drive)
                begin
                    failed = 1'b1;
                end
                else if (hv_ack && !init_line && done_line)
                begin
                    phase_next = rtdseq_pkg::PH_TS_READY;
                end
            end
            rtdseq_pkg::PH_TS_READY:
            begin
                dc_on  = 1'b1;
                inv_on = 1'b1;
                if (!ended || !ready)
                begin
                    failed = 1'b1;
                end
                else if (drive && (s1_item_reg.brake_level > cfg.brake_threshold))
                begin
                    mode = 1'b1;
                    req  = 1'b1;
                    if (s1_item_reg.power_unit_ack)
                    begin
                        enable = 1'b1;
                        if (inv_ack)
                        begin
                            phase_next = rtdseq_pkg::PH_RUNNING;
                        end
                    end
                end
            end
            rtdseq_pkg::PH_RUNNING:
            begin
                if (!inv_ack || !ended || !ready)
                begin
                    failed = 1'b1;
                end
                else if (!drive)
                begin
                    mode       = 1'b1;
                    phase_next = rtdseq_pkg::PH_OFF;
                end
                else
                begin
                    may_send = 1'b0;
                end
            end
            default: ;
        endcase

        // Drop setpoints and return to off on any failure
        fault_next = fault_cur;
        if (failed)
        begin
            fault_next = 1'b1;
            dc_on      = 1'b0;
            inv_on     = 1'b0;
            enable     = 1'b0;
            phase_next = rtdseq_pkg::PH_OFF;
        end
    end

    // Send once the interval has elapsed, modulo 2^32, unless running with drive held
    assign elapsed        = s1_item_reg.now_ms - last_send_reg;
    assign send           = may_send & (elapsed >= {22'd0, cfg.send_interval_ms});
    assign last_send_next = send ? s1_item_reg.now_ms : last_send_reg;

    always_comb
    begin
        res_next.phase           = phase_next;
        res_next.send_now        = send;
        res_next.cmd_hv_on       = dc_on;
        res_next.cmd_inverter_on = inv_on;
        res_next.cmd_enable      = enable;
        res_next.pu_mode         = mode;
        res_next.pu_request      = req;
        res_next.fault           = fault_next;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= rtdseq_pkg::PH_OFF;
            mark_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            last_send_reg <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg     <= phase_next;
                mark_reg      <= mark_next;
                fault_reg     <= fault_next;
                last_send_reg <= last_send_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/inverter_ready_to_drive_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// inverter_ready_to_drive_sequencer_top
// Ready-to-drive sequencer for a set of drive inverters.
//
//   Channel  Signals                                   Direction  Payload
//   item     item_valid / item_ready / item            in         item_t
//   result   result_valid / result_ready / result      out        result_t
//   config   psel penable pwrite paddr pwdata prdata   in/out     two regs
//
// One update tick per clock while the result is not stalled: an accepted
// item is held in the input register, and its result is written into the
// result register once that register is free or being drained.
// A stalled result holds the result register; the input register keeps
// taking an item whenever its contents move on in the same cycle.
// Reset puts the sequencer in off with no fault and a last send time of zero.
// ----------------------------------------------------------------------------
module inverter_ready_to_drive_sequencer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtdseq_pkg::PADDR_W-1:0] paddr,
    input  logic [rtdseq_pkg::PDATA_W-1:0] pwdata,
    output logic [rtdseq_pkg::PDATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  rtdseq_pkg::item_t              item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output rtdseq_pkg::result_t            result
);

    rtdseq_pkg::cfg_t cfg;

    rtdseq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtdseq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // A raised fault always comes with the sequencer back in off
    a_fault_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fault |-> result.phase == rtdseq_pkg::PH_OFF)
        else $error("fault raised outside off phase");

    // Drive enable only with the controller enable level and power unit request set
    a_enable_inv: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.cmd_enable |-> result.cmd_inverter_on && result.pu_request)
        else $error("drive enable without inverter on or request");

    // Controller enable only with high voltage activation set
    a_inv_hv: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.cmd_inverter_on |-> result.cmd_hv_on)
        else $error("inverter on without hv on");
`endif

endmodule

// ===== verif/rtdseq_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdseq_scoreboard_pkg
// Tick predictor and outcome scoreboard for the ready-to-drive sequencer.
// The class keeps its own copy of the sequencer state and the two
// configuration registers, predicts the outcome of every accepted tick and
// compares each transferred result against the oldest pending outcome.
// ----------------------------------------------------------------------------
package rtdseq_scoreboard_pkg;

    import rtdseq_pkg::*;

    class sequencer_scoreboard;

        // Mirrored sequencer state
        logic [1:0]  seq_phase;
        logic        precharge_seen;
        logic        fault_raised;
        logic [31:0] last_send_ms;

        // Mirrored configuration
        logic [6:0]  brake_threshold;
        logic [9:0]  send_interval;

        result_t     pending_ticks[$];
        int          mismatches;
        int          checked_count;

        function new();
            seq_phase       = PH_OFF;
            precharge_seen  = 1'b0;
            fault_raised    = 1'b0;
            last_send_ms    = '0;
            brake_threshold = BRAKE_THRESHOLD_RESET;
            send_interval   = SEND_INTERVAL_MS_RESET;
            mismatches      = 0;
            checked_count   = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_BRAKE_THRESHOLD)
                brake_threshold = value[6:0];
            else
                send_interval = value[9:0];
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        // Advance the mirrored sequencer by one tick and return its outcome
        function result_t predict_tick(item_t it);
            logic [ENGINE_BITS-1:0] mask;
            logic    rdy, hvon, hvack, invack, ended, failed, may_send;
            logic [31:0] elapsed;
            result_t r;
            mask = '0;
            for (int i = 0; i < NUM_ENGINES; i++)
                mask[i] = 1'b1;
            rdy      = |(it.ready_bits & mask);
            hvon     = |(it.hv_on_bits & mask);
            hvack    = |(it.hv_ack_bits & mask);
            invack   = |(it.inv_ack_bits & mask);
            r        = '0;
            may_send = 1'b1;
            failed   = 1'b0;

            // A tick that begins in off clears the fault
            if (seq_phase == PH_OFF)
                fault_raised = 1'b0;

            case (seq_phase)
                PH_OFF:
                begin
                    precharge_seen = 1'b0;
                    r.cmd_hv_on = rdy;
                    if (!fault_raised && rdy && hvon && hvack && !it.precharge_init_line
                        && !it.precharge_done_line && !it.drive_request)
                        seq_phase = PH_PRECHARGE;
                    else if (it.drive_request || fault_raised)
                        failed = 1'b1;
                end
                PH_PRECHARGE:
                begin
                    precharge_seen = 1'b1;
                    r.cmd_hv_on = 1'b1;
                    ended = hvack && !it.precharge_init_line && it.precharge_done_line;
                    if (!rdy || it.drive_request)
                        failed = 1'b1;
                    else if (ended)
                        seq_phase = PH_TS_READY;
                end
                PH_TS_READY:
                begin
                    r.cmd_hv_on       = 1'b1;
                    r.cmd_inverter_on = 1'b1;
                    ended = hvack && precharge_seen && !it.precharge_init_line
                            && it.precharge_done_line;
                    if (!hvack || !ended || !rdy)
                        failed = 1'b1;
                    else if (it.drive_request && it.brake_level > brake_threshold)
                    begin
                        r.pu_mode    = 1'b1;
                        r.pu_request = 1'b1;
                        if (it.power_unit_ack)
                        begin
                            r.cmd_enable = 1'b1;
                            if (invack)
                                seq_phase = PH_RUNNING;
                        end
                    end
                end
                default:
                begin
                    ended = hvack && precharge_seen && !it.precharge_init_line
                            && it.precharge_done_line;
                    if (!invack || !hvack || !ended || !rdy)
                        failed = 1'b1;
                    else if (!it.drive_request)
                    begin
                        r.pu_mode = 1'b1;
                        seq_phase = PH_OFF;
                    end
                    else
                        may_send = 1'b0;
                end
            endcase

            // Any failure drops the setpoints and returns to off
            if (failed)
            begin
                fault_raised      = 1'b1;
                r.cmd_hv_on       = 1'b0;
                r.cmd_inverter_on = 1'b0;
                r.cmd_enable      = 1'b0;
                seq_phase         = PH_OFF;
            end

            elapsed = it.now_ms - last_send_ms;
            if (may_send && elapsed >= {22'b0, send_interval})
            begin
                r.send_now   = 1'b1;
                last_send_ms = it.now_ms;
            end

            r.phase = seq_phase;
            r.fault = fault_raised;
            return r;
        endfunction

        function void note_tick(item_t it);
            pending_ticks.push_back(predict_tick(it));
        endfunction

        function string show(result_t r);
            return $sformatf("phase=%0d send=%b hv=%b inv=%b en=%b mode=%b req=%b fault=%b",
                             r.phase, r.send_now, r.cmd_hv_on, r.cmd_inverter_on,
                             r.cmd_enable, r.pu_mode, r.pu_request, r.fault);
        endfunction

        function void check_outcome(result_t got);
            result_t want;
            string   bad;
            checked_count++;
            if (pending_ticks.size() == 0)
            begin
                flag({"result with no pending tick: ", show(got)});
                return;
            end
            want = pending_ticks.pop_front();
            bad  = "";
            if (got.phase !== want.phase)                     bad = {bad, " phase"};
            if (got.send_now !== want.send_now)               bad = {bad, " send_now"};
            if (got.cmd_hv_on !== want.cmd_hv_on)             bad = {bad, " cmd_hv_on"};
            if (got.cmd_inverter_on !== want.cmd_inverter_on) bad = {bad, " cmd_inverter_on"};
            if (got.cmd_enable !== want.cmd_enable)           bad = {bad, " cmd_enable"};
            if (got.pu_mode !== want.pu_mode)                 bad = {bad, " pu_mode"};
            if (got.pu_request !== want.pu_request)           bad = {bad, " pu_request"};
            if (got.fault !== want.fault)                     bad = {bad, " fault"};
            if (bad != "")
                flag($sformatf("result %0d differs in%s: expected %s, got %s",
                               checked_count, bad, show(want), show(got)));
        endfunction

        function void finish_check();
            if (pending_ticks.size() != 0)
                flag($sformatf("%0d ticks never produced a result", pending_ticks.size()));
        endfunction

    endclass

endpackage

// ===== verif/inverter_ready_to_drive_sequencer_top_test.sv =====
// ----------------------------------------------------------------------------
// inverter_ready_to_drive_sequencer_top_test
// Self-checking bench for the ready-to-drive sequencer. A directed walk
// through every phase and every exit, with one failure per phase, comes
// first, then mostly well-formed random sequences across several register
// settings, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module inverter_ready_to_drive_sequencer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rtdseq_pkg::*;
    import rtdseq_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ROUND_TICKS = 135;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    item_t               tick_bus     = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             outcome;

    sequencer_scoreboard sb = new();
    logic [31:0]         clock_ms     = '0;
    logic                no_idle      = 1'b0;
    logic                want_hold    = 1'b0;
    int                  cycles       = 0;

    inverter_ready_to_drive_sequencer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (tick_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (outcome)
    );

    always #10 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ENGINE_BITS-1:0] some_engines();
        return ENGINE_BITS'($urandom_range(1, 15));
    endfunction

    // Advance the millisecond clock: small steps, some jumps, rare wild values
    function automatic logic [31:0] advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, 20);
        else if (r < 90)
            clock_ms = clock_ms + $urandom_range(0, 1500);
        else if (r < 97)
            clock_ms = $urandom();
        return clock_ms;
    endfunction

    function automatic item_t random_tick();
        item_t t;
        t.ready_bits          = ENGINE_BITS'($urandom_range(0, 15));
        t.hv_on_bits          = ENGINE_BITS'($urandom_range(0, 15));
        t.hv_ack_bits         = ENGINE_BITS'($urandom_range(0, 15));
        t.inv_ack_bits        = ENGINE_BITS'($urandom_range(0, 15));
        t.precharge_init_line = 1'($urandom_range(0, 1));
        t.precharge_done_line = 1'($urandom_range(0, 1));
        t.drive_request       = 1'($urandom_range(0, 1));
        t.brake_level         = 7'($urandom_range(0, 100));
        t.power_unit_ack      = 1'($urandom_range(0, 1));
        t.now_ms              = '0;
        return t;
    endfunction

    // Build a tick that moves the sequencer on from its current phase,
    // with random content and an occasional broken condition
    function automatic item_t shaped_tick();
        item_t t;
        t = random_tick();
        case (sb.seq_phase)
            PH_OFF:
            begin
                t.ready_bits          = some_engines();
                t.hv_on_bits          = some_engines();
                t.hv_ack_bits         = some_engines();
                t.precharge_init_line = 1'b0;
                t.precharge_done_line = 1'b0;
                t.drive_request       = ($urandom_range(0, 9) == 0);
            end
            PH_PRECHARGE:
            begin
                t.ready_bits          = some_engines();
                t.hv_ack_bits         = some_engines();
                t.precharge_init_line = 1'b0;
                t.precharge_done_line = ($urandom_range(0, 4) < 3);
                t.drive_request       = ($urandom_range(0, 19) == 0);
            end
            PH_TS_READY:
            begin
                t.ready_bits          = some_engines();
                t.hv_ack_bits         = some_engines();
                t.precharge_init_line = 1'b0;
                t.precharge_done_line = 1'b1;
                t.drive_request       = ($urandom_range(0, 4) != 0);
                t.power_unit_ack      = ($urandom_range(0, 3) != 0);
                t.inv_ack_bits        = ($urandom_range(0, 3) != 0) ? some_engines() : '0;
            end
            default:
            begin
                t.ready_bits          = some_engines();
                t.hv_ack_bits         = some_engines();
                t.inv_ack_bits        = some_engines();
                t.precharge_init_line = 1'b0;
                t.precharge_done_line = 1'b1;
                t.drive_request       = ($urandom_range(0, 9) != 0);
            end
        endcase
        return t;
    endfunction

    // Offer one tick after a gap and hold it until the transfer
    task automatic offer_tick(input item_t t, input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        tick_bus   <= t;
        do @(posedge clk); while (!item_ready);
        sb.note_tick(t);
    endtask

    task automatic tick(input logic [3:0] rdy, input logic [3:0] hvon,
                        input logic [3:0] hvack, input logic [3:0] invack,
                        input int init, input int done, input int drive,
                        input int brake, input int pu_ack, input int dt);
        item_t t;
        clock_ms              = clock_ms + dt;
        t.ready_bits          = rdy;
        t.hv_on_bits          = hvon;
        t.hv_ack_bits         = hvack;
        t.inv_ack_bits        = invack;
        t.precharge_init_line = (init != 0);
        t.precharge_done_line = (done != 0);
        t.drive_request       = (drive != 0);
        t.brake_level         = 7'(brake);
        t.power_unit_ack      = (pu_ack != 0);
        t.now_ms              = clock_ms;
        offer_tick(t, 0);
    endtask

    // Drop valid and wait until every pending outcome has arrived
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_access(input logic idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, mirror it and read it back
    task automatic program_register(input logic idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        reg_access(idx, 1'b1, value, rd);
        sb.set_register(idx, value);
        want = (idx == REG_BRAKE_THRESHOLD) ? {25'b0, value[6:0]} : {22'b0, value[9:0]};
        reg_access(idx, 1'b0, '0, rd);
        if (rd !== want)
            sb.flag($sformatf("register %0d read back %h, expected %h", idx, rd, want));
    endtask

    // Result side: random back-pressure, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_outcome(outcome);
            if (want_hold)
            begin
                want_hold  = 1'b0;
                stall_left = 250;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_cycles();
            end
        end
    end

    initial
    begin
        int thr_plan [6];
        int gap_plan [6];
        item_t t;
        thr_plan = '{0, 100, 0, 0, 50, 20};
        gap_plan = '{1, 1000, 1, 1, 0, 10};
        thr_plan[2] = $urandom_range(0, 100);
        thr_plan[3] = $urandom_range(0, 100);
        gap_plan[2] = $urandom_range(1, 1000);
        gap_plan[3] = $urandom_range(1, 1000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_register(REG_BRAKE_THRESHOLD, 32'd20);
        program_register(REG_SEND_INTERVAL_MS, 32'd10);

        // Directed walk: rdy, hvon, hvack, invack, init, done, drive, brake, pu, dt
        tick(4'h0, 4'h0, 4'h0, 4'h0, 0, 0, 0,   0, 0, 0);  // idle in off
        tick(4'h1, 4'h0, 4'h0, 4'h0, 0, 0, 1,   0, 0, 3);  // drive request in off
        clock_ms = 32'hFFFF_FFFE;
        tick(4'h2, 4'h2, 4'h2, 4'h0, 0, 0, 0, 100, 0, 1);  // start precharge, time at top
        tick(4'h8, 4'h0, 4'h4, 4'h0, 1, 0, 0,   0, 0, 1);  // init line holds precharge
        tick(4'hF, 4'hF, 4'hF, 4'h0, 0, 1, 0,   0, 0, 10); // precharge done
        tick(4'h1, 4'h0, 4'h1, 4'h0, 0, 1, 1,  20, 1, 5);  // brake equal to threshold
        tick(4'h1, 4'h0, 4'h1, 4'h0, 0, 1, 1,  21, 0, 5);  // request, no ack
        tick(4'h4, 4'h0, 4'h2, 4'h0, 0, 1, 1, 100, 1, 5);  // enable, inverters not ready
        tick(4'h4, 4'h0, 4'h2, 4'h1, 0, 1, 1, 100, 1, 5);  // enter running
        tick(4'h2, 4'h0, 4'h8, 4'h8, 0, 1, 1,   0, 0, 100);// normal running, no send
        tick(4'h2, 4'h0, 4'h8, 4'h8, 0, 1, 0,   0, 0, 1);  // driver releases
        tick(4'h8, 4'h8, 4'h8, 4'h0, 0, 0, 0,  50, 0, 10);
        tick(4'h8, 4'h0, 4'h8, 4'h0, 0, 0, 1,  50, 0, 10); // drive during precharge
        tick(4'h0, 4'hF, 4'hF, 4'hF, 0, 0, 0,  50, 1, 10); // clear fault
        tick(4'h1, 4'h1, 4'h1, 4'h0, 0, 0, 0,  50, 0, 10);
        tick(4'h1, 4'h0, 4'h1, 4'h0, 0, 1, 0,  50, 0, 10);
        tick(4'h1, 4'h0, 4'h0, 4'hF, 0, 1, 1, 100, 1, 10); // lost ack in ts ready
        tick(4'h4, 4'h4, 4'h4, 4'h0, 0, 0, 0,   0, 0, 10);
        tick(4'h4, 4'h0, 4'h4, 4'h0, 0, 1, 0,   0, 0, 10);
        tick(4'h4, 4'h0, 4'h4, 4'h0, 0, 1, 0,   0, 0, 10); // wait in ts ready
        tick(4'h4, 4'h0, 4'h4, 4'h4, 0, 1, 1,  99, 1, 10);
        tick(4'h4, 4'h0, 4'h4, 4'h0, 0, 1, 1,  99, 1, 10); // inverter ack lost
        tick(4'hF, 4'h0, 4'h0, 4'h0, 0, 0, 0,   0, 0, 10); // ready, no hv ack
        tick(4'hF, 4'hF, 4'hF, 4'hF, 1, 1, 0, 100, 1, 10); // lines high in off
        drain();

        // Random rounds, one per register setting
        for (int round = 0; round < 6; round++)
        begin
            program_register(REG_BRAKE_THRESHOLD, thr_plan[round]);
            program_register(REG_SEND_INTERVAL_MS, gap_plan[round]);
            no_idle = (round == 3);
            if (round == 1)
                want_hold = 1'b1;
            for (int n = 0; n < ROUND_TICKS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
                t = ($urandom_range(0, 99) < 80) ? shaped_tick() : random_tick();
                t.now_ms = advance_clock();
                offer_tick(t, idle_cycles());
            end
            drain();
        end

        sb.finish_check();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
